// File: rtl/hcl_pkg.sv
`default_nettype none
package hcl_pkg;

  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_UD    = 8'h44;

  // Operands must fit in this many bits
  localparam int unsigned OPERAND_BITS = 16;
  localparam int unsigned ACTION_BITS  = 4;
  localparam int unsigned OUT_BYTES    = 5;

  typedef enum logic [1:0] {
    KIND_ESC,
    KIND_ENTER,
    KIND_SPACE,
    KIND_OTHER
  } kind_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_READ,
    CMD_WRITE,
    CMD_CROP,
    CMD_DUMP,
    CMD_TOTAL,
    CMD_ZOOM,
    CMD_DBG_OFF,
    CMD_DBG_ON
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_CMD,
    MODE_ADDR,
    MODE_DATA
  } mode_t;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_NONE       = 4'd0,
    ACT_PROMPT     = 4'd1,
    ACT_READ       = 4'd2,
    ACT_WRITE      = 4'd3,
    ACT_CROP       = 4'd4,
    ACT_UNKNOWN    = 4'd5,
    ACT_DATA_RANGE = 4'd6,
    ACT_ADDR_RANGE = 4'd7,
    ACT_DUMP       = 4'd8,
    ACT_SIZE_TOTAL = 4'd9,
    ACT_SIZE_ZOOM  = 4'd10,
    ACT_DEBUG_OFF  = 4'd11,
    ACT_DEBUG_ON   = 4'd12
  } action_t;

  // Classified character: dneg marks a digit worth minus one
  typedef struct packed {
    kind_t      kind;
    cmd_t       cmd;
    logic       dneg;
    logic [5:0] dval;
  } token_t;

endpackage
`default_nettype wire

// File: rtl/hex_command_line_parser.sv
// Serial command-line parser: one received character per request on the
// in_ side, one result per character on the out_ side, in order. A new
// character is taken every clock cycle while the result side keeps up; the
// sustained rate is one character per cycle, set by the executor that
// updates the parse state. Each character's result passes in order through
// the classifier register, the two-entry queue and the result register
// before it is offered on the out_ side as a registered result, and while
// out_tready is low the input keeps flowing for up to three more characters
// (two queue entries and the classifier register). The letter at the prompt
// picks the command; w, r and c are followed by a hex address, a space and hex
// data, accumulated ACC_WIDTH bits wide. CR or LF executes and range-checks
// both operands against 16 bits; ESC abandons the line.
`default_nettype none
module hex_command_line_parser
  import hcl_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] rx_char
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [3:0] action, [19:4] address, [35:20] data, [36] led_toggle,
  // [37] debug_enabled, [39:38] zero
  output logic [8*OUT_BYTES-1:0]      out_tdata
);

  // Front to queue
  logic    ft_valid, ft_ready;
  token_t  ft_tok;
  // Queue to back end
  logic    qb_valid, qb_ready;
  token_t  qb_tok;

  action_t                 res_action;
  logic [OPERAND_BITS-1:0] res_address, res_data;
  logic                    res_led, res_debug;

  // Classify each character as it arrives
  hcl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_char   (in_tdata),
    .tok_valid (ft_valid),
    .tok_ready (ft_ready),
    .tok       (ft_tok)
  );

  // Decouple classification from execution
  hcl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (ft_valid),
    .wr_ready (ft_ready),
    .wr_tok   (ft_tok),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_tok   (qb_tok)
  );

  // Advance the parse state and hold the result until taken
  hcl_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_valid   (qb_valid),
    .tok_ready   (qb_ready),
    .tok         (qb_tok),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_action  (res_action),
    .res_address (res_address),
    .res_data    (res_data),
    .res_led     (res_led),
    .res_debug   (res_debug)
  );

  // Pack fields from the lowest bit up, pad to whole bytes
  assign out_tdata = (8*OUT_BYTES)'({res_debug, res_led, res_data, res_address,
                                    res_action});

endmodule
`default_nettype wire

// File: rtl/hcl_front.sv
`default_nettype none
module hcl_front
  import hcl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char,
  output logic            tok_valid,
  input  wire logic       tok_ready,
  output token_t          tok
);

  logic   valid_r, valid_nxt;
  token_t tok_r, tok_nxt;

  always_comb begin
    tok_nxt.kind = KIND_OTHER;
    tok_nxt.cmd  = CMD_NONE;
    tok_nxt.dneg = 1'b0;
    tok_nxt.dval = '0;
    if (in_char == CH_ESC) begin
      tok_nxt.kind = KIND_ESC;
    end else if (in_char == CH_CR || in_char == CH_LF) begin
      tok_nxt.kind = KIND_ENTER;
    end else if (in_char == CH_SPACE) begin
      tok_nxt.kind = KIND_SPACE;
    end
    priority if (in_char >= CH_0 && in_char <= CH_9) begin
      tok_nxt.dval = 6'(in_char - CH_0);
    end else if (in_char >= CH_LA && in_char <= CH_LZ) begin
      tok_nxt.dval = 6'(in_char - CH_LA + 8'd10);
    end else if (in_char >= CH_UA && in_char <= CH_UZ) begin
      tok_nxt.dval = 6'(in_char - CH_UA + 8'd10);
    end else begin
      tok_nxt.dneg = 1'b1;
    end
    unique case (in_char)
      CH_R:    tok_nxt.cmd = CMD_READ;
      CH_W:    tok_nxt.cmd = CMD_WRITE;
      CH_C:    tok_nxt.cmd = CMD_CROP;
      CH_S:    tok_nxt.cmd = CMD_DUMP;
      CH_T:    tok_nxt.cmd = CMD_TOTAL;
      CH_Z:    tok_nxt.cmd = CMD_ZOOM;
      CH_LD:   tok_nxt.cmd = CMD_DBG_OFF;
      CH_UD:   tok_nxt.cmd = CMD_DBG_ON;
      default: tok_nxt.cmd = CMD_NONE;
    endcase
  end

  assign in_ready  = !valid_r || tok_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_valid = valid_r;
  assign tok       = tok_r;

endmodule
`default_nettype wire

// File: rtl/hcl_queue.sv
`default_nettype none
module hcl_queue
  import hcl_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   wr_valid,
  output logic        wr_ready,
  input  token_t      wr_tok,
  output logic        rd_valid,
  input  wire logic   rd_ready,
  output token_t      rd_tok
);

  token_t     mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_tok;
    end
  end

  assign rd_tok = mem[rd_ptr_r];

endmodule
`default_nettype wire

// File: rtl/hcl_back.sv
`default_nettype none
module hcl_back
  import hcl_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    tok_valid,
  output logic                         tok_ready,
  input  token_t                       tok,
  output logic                         res_valid,
  input  wire logic                    res_ready,
  output action_t                      res_action,
  output logic [OPERAND_BITS-1:0]      res_address,
  output logic [OPERAND_BITS-1:0]      res_data,
  output logic                         res_led,
  output logic                         res_debug
);

  mode_t                 mode_r, mode_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [ACC_WIDTH-1:0]  addr_acc_r, addr_acc_nxt;
  logic [ACC_WIDTH-1:0]  data_acc_r, data_acc_nxt;
  logic                  dbg_r, dbg_nxt;
  logic                  valid_r, valid_nxt;

  action_t               act_nxt, act_r;
  logic [OPERAND_BITS-1:0] addr_o_nxt, addr_o_r, data_o_nxt, data_o_r;
  logic                  led_nxt, led_r;

  logic [ACC_WIDTH-1:0]  digit;
  logic [ACC_WIDTH-1:0]  addr_push, data_push;
  logic                  addr_big, data_big;
  logic                  fire;

  assign tok_ready = !valid_r || res_ready;
  assign fire      = tok_valid && tok_ready;

  assign digit     = tok.dneg ? '1 : ACC_WIDTH'(tok.dval);
  assign addr_push = (addr_acc_r << 4) + digit;
  assign data_push = (data_acc_r << 4) + digit;
  assign addr_big  = |addr_acc_r[ACC_WIDTH-1:OPERAND_BITS];
  assign data_big  = |data_acc_r[ACC_WIDTH-1:OPERAND_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_CMD;
      cmd_r      <= CMD_NONE;
      addr_acc_r <= '0;
      data_acc_r <= '0;
      dbg_r      <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      cmd_r      <= cmd_nxt;
      addr_acc_r <= addr_acc_nxt;
      data_acc_r <= data_acc_nxt;
      dbg_r      <= dbg_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    cmd_nxt      = cmd_r;
    addr_acc_nxt = addr_acc_r;
    data_acc_nxt = data_acc_r;
    dbg_nxt      = dbg_r;
    act_nxt      = ACT_NONE;
    addr_o_nxt   = '0;
    data_o_nxt   = '0;
    led_nxt      = 1'b1;
    valid_nxt    = tok_ready ? tok_valid : valid_r;
    if (fire) begin
      priority if (tok.kind == KIND_ESC) begin
        mode_nxt = MODE_CMD;
        act_nxt  = ACT_PROMPT;
        led_nxt  = 1'b0;
      end else if (tok.kind == KIND_ENTER) begin
        mode_nxt = MODE_CMD;
        priority if (addr_big) begin
          act_nxt = ACT_ADDR_RANGE;
        end else if (data_big) begin
          act_nxt = ACT_DATA_RANGE;
        end else if (cmd_r == CMD_READ || cmd_r == CMD_WRITE || cmd_r == CMD_CROP) begin
          act_nxt    = (cmd_r == CMD_READ)  ? ACT_READ :
                       (cmd_r == CMD_WRITE) ? ACT_WRITE : ACT_CROP;
          addr_o_nxt = addr_acc_r[OPERAND_BITS-1:0];
          data_o_nxt = data_acc_r[OPERAND_BITS-1:0];
        end else begin
          act_nxt = ACT_UNKNOWN;
        end
      end else if (mode_r == MODE_ADDR) begin
        if (tok.kind == KIND_SPACE) begin
          mode_nxt = MODE_DATA;
        end else begin
          addr_acc_nxt = addr_push;
        end
      end else if (mode_r == MODE_DATA) begin
        data_acc_nxt = data_push;
      end else begin
        cmd_nxt = tok.cmd;
        unique case (tok.cmd)
          CMD_READ, CMD_WRITE, CMD_CROP: begin
            mode_nxt     = MODE_ADDR;
            addr_acc_nxt = '0;
            data_acc_nxt = '0;
          end
          CMD_DUMP:    act_nxt = ACT_DUMP;
          CMD_TOTAL:   act_nxt = ACT_SIZE_TOTAL;
          CMD_ZOOM:    act_nxt = ACT_SIZE_ZOOM;
          CMD_DBG_OFF: begin
            dbg_nxt = 1'b0;
            act_nxt = ACT_DEBUG_OFF;
          end
          CMD_DBG_ON: begin
            dbg_nxt = 1'b1;
            act_nxt = ACT_DEBUG_ON;
          end
          default:     act_nxt = ACT_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      act_r    <= act_nxt;
      addr_o_r <= addr_o_nxt;
      data_o_r <= data_o_nxt;
      led_r    <= led_nxt;
    end
  end

  assign res_valid   = valid_r;
  assign res_action  = act_r;
  assign res_address = addr_o_r;
  assign res_data    = data_o_r;
  assign res_led     = led_r;
  assign res_debug   = dbg_r;

endmodule
`default_nettype wire
